// ----- rtl/iso2ep_pkg.sv -----
// shared types, constants and lookup functions for the iso-8601 to epoch block
`default_nettype none

package iso2ep_pkg;

    localparam int RECORD_LAST   = 19;
    localparam int POS_W         = 5;
    localparam int YEAR_W        = 14;
    localparam int FIELD_W       = 7;
    localparam int DAYS_W        = 23;
    localparam int HMS_W         = 17;
    localparam int PROD_W        = 40;
    localparam int EPOCH_W       = 38;
    localparam int DBM_W         = 9;

    localparam int SEC_PER_DAY   = 86400;
    localparam int SEC_PER_HOUR  = 3600;
    localparam int SEC_PER_MIN   = 60;
    localparam int DAYS_PER_YEAR = 365;
    localparam int EPOCH_YEAR    = 1970;
    localparam int FIRST_LEAP    = 1972;
    localparam int MAX_MIN_SEC   = 59;
    localparam int MAX_HOUR      = 23;
    localparam int MAX_DAY       = 31;
    localparam int MAX_MONTH     = 12;

    localparam int QDEPTH        = 2;
    localparam int QPTR_W        = $clog2(QDEPTH);
    localparam int QCNT_W        = $clog2(QDEPTH + 1);

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;

    typedef enum logic [2:0] {
        FLD_YEAR   = 3'd0,
        FLD_MONTH  = 3'd1,
        FLD_DAY    = 3'd2,
        FLD_HOUR   = 3'd3,
        FLD_MINUTE = 3'd4,
        FLD_SECOND = 3'd5,
        FLD_SEP    = 3'd7
    } t_field;

    typedef struct packed {
        logic [7:0] ch;
        logic       start_req;
    } t_in_item;

    typedef struct packed {
        logic [EPOCH_W-1:0] epoch_seconds;
        logic               valid_res;
    } t_out_item;

    // fields of one parsed record, handed from parser to arithmetic
    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [FIELD_W-1:0] month;
        logic [FIELD_W-1:0] day;
        logic [FIELD_W-1:0] hour;
        logic [FIELD_W-1:0] minute;
        logic [FIELD_W-1:0] second;
    } t_rec;

    function automatic t_field pos_field(input logic [POS_W-1:0] pos);
        t_field f;
        unique case (pos) inside
            5'd0, 5'd1, 5'd2, 5'd3: f = FLD_YEAR;
            5'd5, 5'd6:             f = FLD_MONTH;
            5'd8, 5'd9:             f = FLD_DAY;
            5'd11, 5'd12:           f = FLD_HOUR;
            5'd14, 5'd15:           f = FLD_MINUTE;
            5'd17, 5'd18:           f = FLD_SECOND;
            default:                f = FLD_SEP;
        endcase
        return f;
    endfunction

    function automatic logic [DBM_W-1:0] days_before_month(input logic [FIELD_W-1:0] month);
        logic [DBM_W-1:0] d;
        unique case (month)
            7'd2:    d = 9'd31;
            7'd3:    d = 9'd59;
            7'd4:    d = 9'd90;
            7'd5:    d = 9'd120;
            7'd6:    d = 9'd151;
            7'd7:    d = 9'd181;
            7'd8:    d = 9'd212;
            7'd9:    d = 9'd243;
            7'd10:   d = 9'd273;
            7'd11:   d = 9'd304;
            7'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/iso2ep_front.sv -----
// character parser: tracks record position and accumulates the six numeric fields
`default_nettype none

module iso2ep_front (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_take,
    input  wire iso2ep_pkg::t_in_item  i_item,
    output logic                       o_push,
    output iso2ep_pkg::t_rec           o_rec
);

    logic [iso2ep_pkg::POS_W-1:0]   r_pos, n_pos, pos;
    logic [iso2ep_pkg::YEAR_W-1:0]  r_year, n_year, b_year;
    logic [iso2ep_pkg::FIELD_W-1:0] r_month, n_month, b_month;
    logic [iso2ep_pkg::FIELD_W-1:0] r_day, n_day, b_day;
    logic [iso2ep_pkg::FIELD_W-1:0] r_hour, n_hour, b_hour;
    logic [iso2ep_pkg::FIELD_W-1:0] r_minute, n_minute, b_minute;
    logic [iso2ep_pkg::FIELD_W-1:0] r_second, n_second, b_second;
    logic                           r_open, n_open, b_open;
    logic                           is_digit, first, last;
    logic [3:0]                     digit;
    iso2ep_pkg::t_field             fld;

    function automatic logic [iso2ep_pkg::FIELD_W-1:0] take7(
        input logic [iso2ep_pkg::FIELD_W-1:0] acc, input logic [3:0] d);
        return (acc << 3) + (acc << 1) + iso2ep_pkg::FIELD_W'(d);
    endfunction

    always_comb begin
        pos = i_item.start_req ? '0 : r_pos;
        if (pos > iso2ep_pkg::POS_W'(iso2ep_pkg::RECORD_LAST)) begin
            pos = '0;
        end
        first    = (pos == '0);
        last     = (pos == iso2ep_pkg::POS_W'(iso2ep_pkg::RECORD_LAST));
        fld      = iso2ep_pkg::pos_field(pos);
        is_digit = (i_item.ch >= iso2ep_pkg::CHAR_ZERO) && (i_item.ch <= iso2ep_pkg::CHAR_NINE);
        digit    = 4'(i_item.ch - iso2ep_pkg::CHAR_ZERO);

        // a new record starts from cleared fields
        b_year   = first ? '0 : r_year;
        b_month  = first ? '0 : r_month;
        b_day    = first ? '0 : r_day;
        b_hour   = first ? '0 : r_hour;
        b_minute = first ? '0 : r_minute;
        b_second = first ? '0 : r_second;
        b_open   = first ? 1'b1 : r_open;

        n_year   = b_year;
        n_month  = b_month;
        n_day    = b_day;
        n_hour   = b_hour;
        n_minute = b_minute;
        n_second = b_second;
        n_open   = b_open;

        if (fld == iso2ep_pkg::FLD_SEP) begin
            n_open = 1'b1;
        end else if (b_open) begin
            if (is_digit) begin
                unique case (fld)
                    iso2ep_pkg::FLD_YEAR:   n_year = (b_year << 3) + (b_year << 1)
                                                     + iso2ep_pkg::YEAR_W'(digit);
                    iso2ep_pkg::FLD_MONTH:  n_month  = take7(b_month, digit);
                    iso2ep_pkg::FLD_DAY:    n_day    = take7(b_day, digit);
                    iso2ep_pkg::FLD_HOUR:   n_hour   = take7(b_hour, digit);
                    iso2ep_pkg::FLD_MINUTE: n_minute = take7(b_minute, digit);
                    default:                n_second = take7(b_second, digit);
                endcase
            end else begin
                n_open = 1'b0;
            end
        end

        n_pos = last ? '0 : pos + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_year   <= '0;
            r_month  <= '0;
            r_day    <= '0;
            r_hour   <= '0;
            r_minute <= '0;
            r_second <= '0;
            r_open   <= 1'b1;
        end else if (i_take) begin
            r_pos    <= n_pos;
            r_year   <= n_year;
            r_month  <= n_month;
            r_day    <= n_day;
            r_hour   <= n_hour;
            r_minute <= n_minute;
            r_second <= n_second;
            r_open   <= n_open;
        end
    end

    // the last byte is a separator, so the record leaves with the fields as they stand
    assign o_push = i_take && last;
    always_comb begin
        o_rec.year   = n_year;
        o_rec.month  = n_month;
        o_rec.day    = n_day;
        o_rec.hour   = n_hour;
        o_rec.minute = n_minute;
        o_rec.second = n_second;
    end

endmodule

`default_nettype wire

// ----- rtl/iso2ep_fifo.sv -----
// two-entry record queue between parser and arithmetic
`default_nettype none

module iso2ep_fifo (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire iso2ep_pkg::t_rec   i_rec,
    input  wire logic               i_pop,
    output logic                    o_full,
    output logic                    o_empty,
    output iso2ep_pkg::t_rec        o_rec
);

    iso2ep_pkg::t_rec                r_mem [iso2ep_pkg::QDEPTH];
    logic [iso2ep_pkg::QPTR_W-1:0]   r_wp, r_rp;
    logic [iso2ep_pkg::QCNT_W-1:0]   r_cnt;
    logic                            do_push, do_pop;

    assign o_full  = (r_cnt == iso2ep_pkg::QCNT_W'(iso2ep_pkg::QDEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rec   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + iso2ep_pkg::QCNT_W'(do_push) - iso2ep_pkg::QCNT_W'(do_pop);
        end
    end

`ifndef ASSERT_OFF
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("record pushed into full queue");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= iso2ep_pkg::QCNT_W'(iso2ep_pkg::QDEPTH))
        else $error("queue count beyond depth");
    a_ptr_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0 || r_cnt == iso2ep_pkg::QCNT_W'(iso2ep_pkg::QDEPTH)) |-> r_wp == r_rp)
        else $error("queue pointers disagree with count");
`endif

endmodule

`default_nettype wire

// ----- rtl/iso2ep_back.sv -----
// epoch arithmetic sequencer with registered output stage
`default_nettype none

module iso2ep_back (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_q_empty,
    input  wire iso2ep_pkg::t_rec      i_rec,
    output logic                       o_pop,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output iso2ep_pkg::t_out_item      o_out_data
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DAYS = 4'b0010,
        S_SECS = 4'b0100,
        S_HOLD = 4'b1000
    } t_state;

    t_state                           r_state, n_state;
    iso2ep_pkg::t_rec                 r_rec;
    logic                             r_ok;
    logic [iso2ep_pkg::DAYS_W-1:0]    r_days;
    logic [iso2ep_pkg::HMS_W-1:0]     r_hms;
    logic [iso2ep_pkg::EPOCH_W-1:0]   r_secs;
    logic                             r_out_valid;
    iso2ep_pkg::t_out_item            r_out;

    logic                             ok, leap_now, out_free;
    logic [iso2ep_pkg::YEAR_W-1:0]    yoff, yleap;
    logic [iso2ep_pkg::DAYS_W-1:0]    days;
    logic [iso2ep_pkg::HMS_W-1:0]     hms;
    logic [iso2ep_pkg::PROD_W-1:0]    total;

    assign out_free = !r_out_valid || !i_out_stall;
    assign o_pop    = (r_state == S_IDLE) && !i_q_empty;

    always_comb begin
        ok = (r_rec.year >= iso2ep_pkg::YEAR_W'(iso2ep_pkg::EPOCH_YEAR))
          && (r_rec.month >= 7'd1)
          && (r_rec.month <= iso2ep_pkg::FIELD_W'(iso2ep_pkg::MAX_MONTH))
          && (r_rec.day >= 7'd1)
          && (r_rec.day <= iso2ep_pkg::FIELD_W'(iso2ep_pkg::MAX_DAY))
          && (r_rec.hour <= iso2ep_pkg::FIELD_W'(iso2ep_pkg::MAX_HOUR))
          && (r_rec.minute <= iso2ep_pkg::FIELD_W'(iso2ep_pkg::MAX_MIN_SEC))
          && (r_rec.second <= iso2ep_pkg::FIELD_W'(iso2ep_pkg::MAX_MIN_SEC));
        yoff  = r_rec.year - iso2ep_pkg::YEAR_W'(iso2ep_pkg::EPOCH_YEAR);
        yleap = r_rec.year - iso2ep_pkg::YEAR_W'(iso2ep_pkg::EPOCH_YEAR - 1);
        leap_now = (r_rec.year >= iso2ep_pkg::YEAR_W'(iso2ep_pkg::FIRST_LEAP))
                && (r_rec.year[1:0] == 2'b00) && (r_rec.month > 7'd2);
        days = iso2ep_pkg::DAYS_W'(yoff) * iso2ep_pkg::DAYS_W'(iso2ep_pkg::DAYS_PER_YEAR)
             + iso2ep_pkg::DAYS_W'(yleap[iso2ep_pkg::YEAR_W-1:2])
             + iso2ep_pkg::DAYS_W'(leap_now)
             + iso2ep_pkg::DAYS_W'(iso2ep_pkg::days_before_month(r_rec.month))
             + iso2ep_pkg::DAYS_W'(r_rec.day) - iso2ep_pkg::DAYS_W'(1);
        hms  = iso2ep_pkg::HMS_W'(r_rec.hour) * iso2ep_pkg::HMS_W'(iso2ep_pkg::SEC_PER_HOUR)
             + iso2ep_pkg::HMS_W'(r_rec.minute) * iso2ep_pkg::HMS_W'(iso2ep_pkg::SEC_PER_MIN)
             + iso2ep_pkg::HMS_W'(r_rec.second);
        total = iso2ep_pkg::PROD_W'(r_days) * iso2ep_pkg::PROD_W'(iso2ep_pkg::SEC_PER_DAY)
              + iso2ep_pkg::PROD_W'(r_hms);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (!i_q_empty) n_state = S_DAYS;
            S_DAYS:  n_state = S_SECS;
            S_SECS:  n_state = S_HOLD;
            S_HOLD:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_HOLD && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rec <= i_rec;
        end
        if (r_state == S_DAYS) begin
            r_ok   <= ok;
            r_days <= days;
            r_hms  <= hms;
        end
        if (r_state == S_SECS) begin
            r_secs <= total[iso2ep_pkg::EPOCH_W-1:0];
        end
        if (r_state == S_HOLD && out_free) begin
            r_out.epoch_seconds <= r_ok ? r_secs : '0;
            r_out.valid_res     <= r_ok;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef ASSERT_OFF
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.valid_res |-> r_out.epoch_seconds == '0)
        else $error("invalid record with nonzero seconds");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_state == S_DAYS)
        else $error("popped record not taken into arithmetic");
    a_hold_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_HOLD && out_free |=> r_out_valid)
        else $error("finished record not presented");
`endif

endmodule

`default_nettype wire

// ----- rtl/iso8601_to_epoch_seconds.sv -----
// top level: iso-8601 zulu record to unix seconds converter
`default_nettype none

// Converts a 20-character record of the form YYYY-MM-DDTHH:MM:SSZ, fed one
// character item per cycle, into Unix seconds plus a valid flag. Each numeric
// field gathers digits until its first non-digit, as atoi would; separator
// places are ignored. start_req on an item forces it to be the first character
// of a new record. The 20th character yields one result item; any field out of
// range gives epoch_seconds = 0 and valid_res = 0. Leap years follow the simple
// every-fourth-year rule. The parser takes one character per cycle and only
// stalls its input when the two-entry record queue is full. The arithmetic
// sequencer steps through its states per record (queue pop, day count with a
// 14x9 multiply plus the time-of-day seconds, day-to-seconds 23x17 multiply,
// output load), waiting out any output stall, so a steady byte stream runs at
// one character item per cycle unless output stalls fill the record queue.
module iso8601_to_epoch_seconds (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire iso2ep_pkg::t_in_item   i_in_data,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output iso2ep_pkg::t_out_item       o_out_data
);

    logic              take;
    logic              push;
    logic              pop;
    logic              q_full;
    logic              q_empty;
    iso2ep_pkg::t_rec  rec_in;
    iso2ep_pkg::t_rec  rec_out;

    // hold input while the record queue is full
    assign o_in_stall = q_full;
    assign take       = i_in_valid && !o_in_stall;

    iso2ep_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_item  (i_in_data),
        .o_push  (push),
        .o_rec   (rec_in)
    );

    iso2ep_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (rec_in),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_rec   (rec_out)
    );

    iso2ep_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_rec       (rec_out),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

`default_nettype wire
